// File: rtl/mib_pkg.sv
`default_nettype none

package mib_pkg;

  // table depths and the address widths that follow from them
  localparam int TriDepth = 4096;
  localparam int VtxDepth = 4096;
  localparam int TriAw    = $clog2(TriDepth);
  localparam int VtxAw    = $clog2(VtxDepth);

  // field widths
  localparam int IdxW     = 12;
  localparam int OffW     = 13;
  localparam int WgtW     = 16;
  localparam int ColW     = 24;
  localparam int ChW      = 8;
  localparam int NumCh    = 3;
  localparam int NumVtx   = 3;

  // arithmetic widths: Q2.14 weight times offset with 4 fraction bits
  localparam int FracBits = 18;
  localparam int ProdW    = WgtW + OffW;
  localparam int SumW     = 32;
  // wide enough to hold any index and the largest depth for range checks
  localparam int ExtW     = 17;

  typedef enum logic [1:0] {
    OpWriteTri = 2'd0,
    OpWriteMem = 2'd1,
    OpBlend    = 2'd2,
    OpPass     = 2'd3
  } op_e;

  typedef logic [NumVtx-1:0][IdxW-1:0] vtx_vec_t;
  typedef logic [NumCh-1:0][OffW-1:0]  off_vec_t;

  // payload that travels down the pipe with a blend or pass transaction
  typedef struct packed {
    op_e                         op;
    logic [NumVtx-1:0][WgtW-1:0] weight;
    logic [ColW-1:0]             src;
  } item_t;

  function automatic logic [TriAw-1:0] tri_addr(input logic [IdxW-1:0] idx);
    logic [ExtW-1:0] ext;
    ext = ExtW'(idx);
    return ext[TriAw-1:0];
  endfunction

  function automatic logic tri_in_range(input logic [IdxW-1:0] idx);
    return ExtW'(idx) < ExtW'(TriDepth);
  endfunction

  function automatic logic [VtxAw-1:0] vtx_addr(input logic [IdxW-1:0] idx);
    logic [ExtW-1:0] ext;
    ext = ExtW'(idx);
    return ext[VtxAw-1:0];
  endfunction

  function automatic logic vtx_in_range(input logic [IdxW-1:0] idx);
    return ExtW'(idx) < ExtW'(VtxDepth);
  endfunction

endpackage

`default_nettype wire

// File: rtl/mib_tri_store.sv
`default_nettype none

module mib_tri_store
  import mib_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [TriAw-1:0] addr_i,
  input  wire vtx_vec_t         wdata_i,
  output vtx_vec_t              rdata_o
);

  vtx_vec_t mem [TriDepth];
  vtx_vec_t rdata_q;

  // single port, read-before-write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/mib_mem_store.sv
`default_nettype none

module mib_mem_store
  import mib_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [VtxAw-1:0]             waddr_i,
  input  wire off_vec_t                     wdata_i,
  input  wire logic [NumVtx-1:0][VtxAw-1:0] raddr_i,
  output off_vec_t [NumVtx-1:0]             rdata_o
);

  // one copy per triangle corner so all three offsets come out together
  off_vec_t mem0 [VtxDepth];
  off_vec_t mem1 [VtxDepth];
  off_vec_t mem2 [VtxDepth];
  off_vec_t [NumVtx-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem0[waddr_i] <= wdata_i;
      mem1[waddr_i] <= wdata_i;
      mem2[waddr_i] <= wdata_i;
    end
    rdata_q[0] <= mem0[raddr_i[0]];
    rdata_q[1] <= mem1[raddr_i[1]];
    rdata_q[2] <= mem2[raddr_i[2]];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/mib_datapath.sv
`default_nettype none

module mib_datapath
  import mib_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire item_t                  item_i,
  input  wire off_vec_t [NumVtx-1:0]  offset_i,
  input  wire logic [NumVtx-1:0]      vtx_ok_i,
  output logic                        valid_o,
  output logic [NumCh-1:0][ChW-1:0]   color_o
);

  typedef logic signed [ProdW-1:0] prod_t;

  logic                             valid_s3_q;
  item_t                            item_s3_q;
  prod_t [NumVtx-1:0][NumCh-1:0]    prod_d, prod_q;

  logic                             valid_out_d, valid_out_q;
  logic [NumCh-1:0][ChW-1:0]        color_d, color_q;

  // stage 3: nine products
  always_comb begin
    prod_t w_ext;
    prod_t o_ext;
    for (int k = 0; k < NumVtx; k++) begin
      for (int c = 0; c < NumCh; c++) begin
        w_ext = ProdW'($signed(item_i.weight[k]));
        o_ext = vtx_ok_i[k] ? ProdW'($signed(offset_i[k][c])) : '0;
        prod_d[k][c] = w_ext * o_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s3_q <= 1'b0;
    end else begin
      valid_s3_q <= valid_i && (item_i.op == OpBlend || item_i.op == OpPass);
    end
  end

  always_ff @(posedge clk_i) begin
    item_s3_q <= item_i;
    prod_q    <= prod_d;
  end

  // stage 4: sum with scaled source, clamp and floor, or pass the source as is
  always_comb begin
    logic signed [SumW-1:0] total;
    logic [ChW-1:0]         src_ch;
    for (int c = 0; c < NumCh; c++) begin
      src_ch = item_s3_q.src[c*ChW +: ChW];
      total  = $signed(SumW'({src_ch, {FracBits{1'b0}}}))
             + SumW'(prod_q[0][c]) + SumW'(prod_q[1][c]) + SumW'(prod_q[2][c]);
      if (item_s3_q.op == OpPass) begin
        color_d[c] = src_ch;
      end else if (total[SumW-1]) begin
        color_d[c] = '0;
      end else if (|total[SumW-2:FracBits+ChW]) begin
        color_d[c] = '1;
      end else begin
        color_d[c] = total[FracBits +: ChW];
      end
    end
    valid_out_d = valid_s3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else begin
      valid_out_q <= valid_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign valid_o = valid_out_q;
  assign color_o = color_q;

endmodule

`default_nettype wire

// File: rtl/membrane_interpolate_blend_unit.sv
`default_nettype none

// membrane interpolate blend unit
//
// command channel: a transaction is taken at each rising edge with start_i high
// and busy_o low; busy_o is always low, so one transaction can be issued every
// cycle. operation_i selects triangle write, membrane write, blend or pass.
// table writes land at once and are seen by every later transaction.
// result channel: blend and pass transactions each give one result, shown on
// color_ch*_o for exactly one cycle with result_valid_o high; writes give none.
// results leave in issue order, through the stage 1, 2, 3 and output registers;
// each is taken at the edge that ends its result_valid_o cycle.
// throughput is one transaction per cycle: the triangle table is read in the
// first stage and three membrane copies, one per corner, are read in the
// second, so no memory port is shared between stages.
// the receiver cannot stall; nothing waits on it.
// reset clears the pipe valid bits only; table contents are undefined until
// software writes them.

module membrane_interpolate_blend_unit
  import mib_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [1:0]              operation_i,
  input  wire logic [IdxW-1:0]         entry_index_i,
  input  wire logic [IdxW-1:0]         vertex_a_i,
  input  wire logic [IdxW-1:0]         vertex_b_i,
  input  wire logic [IdxW-1:0]         vertex_c_i,
  input  wire logic signed [OffW-1:0]  offset_ch0_i,
  input  wire logic signed [OffW-1:0]  offset_ch1_i,
  input  wire logic signed [OffW-1:0]  offset_ch2_i,
  input  wire logic signed [WgtW-1:0]  weight_one_i,
  input  wire logic signed [WgtW-1:0]  weight_two_i,
  input  wire logic signed [WgtW-1:0]  weight_three_i,
  input  wire logic [ColW-1:0]         source_color_i,
  output logic                         result_valid_o,
  output logic [ChW-1:0]               color_ch0_o,
  output logic [ChW-1:0]               color_ch1_o,
  output logic [ChW-1:0]               color_ch2_o
);

  op_e      op;
  logic     accept;
  item_t    item_in;

  // stage 1: triangle read in flight
  logic     valid_s1_q;
  item_t    item_s1_q;
  logic     tri_ok_s1_q;
  vtx_vec_t tri_rdata;

  // stage 2: membrane reads in flight
  logic                         valid_s2_q;
  item_t                        item_s2_q;
  logic [NumVtx-1:0]            vtx_ok_d, vtx_ok_s2_q;
  logic [NumVtx-1:0][VtxAw-1:0] vtx_raddr;
  off_vec_t [NumVtx-1:0]        mem_rdata;

  logic                         tri_we;
  logic                         mem_we;
  logic [NumCh-1:0][ChW-1:0]    color;

  // never busy: every stage moves on each cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign op     = op_e'(operation_i);

  assign item_in.op     = op;
  assign item_in.weight = {weight_three_i, weight_two_i, weight_one_i};
  assign item_in.src    = source_color_i;

  // writes beyond the table depth are dropped
  assign tri_we = accept && op == OpWriteTri && tri_in_range(entry_index_i);
  assign mem_we = accept && op == OpWriteMem && vtx_in_range(entry_index_i);

  mib_tri_store u_tri_store (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .addr_i  (tri_addr(entry_index_i)),
    .wdata_i ({vertex_c_i, vertex_b_i, vertex_a_i}),
    .rdata_o (tri_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
      valid_s2_q <= 1'b0;
    end else begin
      valid_s1_q <= accept;
      valid_s2_q <= valid_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item_s1_q   <= item_in;
    tri_ok_s1_q <= tri_in_range(entry_index_i);
  end

  // out-of-range triangle reads as all-zero vertices; out-of-range vertex
  // reads as a zero offset. a membrane write accepted on the same edge as
  // this read belongs to a later transaction, so read-before-write is right
  always_comb begin
    logic [IdxW-1:0] v;
    for (int k = 0; k < NumVtx; k++) begin
      v            = tri_ok_s1_q ? tri_rdata[k] : '0;
      vtx_ok_d[k]  = vtx_in_range(v);
      vtx_raddr[k] = vtx_addr(v);
    end
  end

  mib_mem_store u_mem_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (vtx_addr(entry_index_i)),
    .wdata_i ({offset_ch2_i, offset_ch1_i, offset_ch0_i}),
    .raddr_i (vtx_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    item_s2_q   <= item_s1_q;
    vtx_ok_s2_q <= vtx_ok_d;
  end

  // weighted sum, clamp and output register
  mib_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_s2_q),
    .item_i   (item_s2_q),
    .offset_i (mem_rdata),
    .vtx_ok_i (vtx_ok_s2_q),
    .valid_o  (result_valid_o),
    .color_o  (color)
  );

  assign color_ch0_o = color[0];
  assign color_ch1_o = color[1];
  assign color_ch2_o = color[2];

endmodule

`default_nettype wire

// File: bench/membrane_blend_checker.sv
module membrane_blend_checker
  import mib_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire logic [1:0]       operation_i,
  input  wire logic [IdxW-1:0]  entry_index_i,
  input  wire logic [IdxW-1:0]  vertex_a_i,
  input  wire logic [IdxW-1:0]  vertex_b_i,
  input  wire logic [IdxW-1:0]  vertex_c_i,
  input  wire logic [OffW-1:0]  offset_ch0_i,
  input  wire logic [OffW-1:0]  offset_ch1_i,
  input  wire logic [OffW-1:0]  offset_ch2_i,
  input  wire logic [WgtW-1:0]  weight_one_i,
  input  wire logic [WgtW-1:0]  weight_two_i,
  input  wire logic [WgtW-1:0]  weight_three_i,
  input  wire logic [ColW-1:0]  source_color_i,
  input  wire logic             result_valid_i,
  input  wire logic [ChW-1:0]   color_ch0_i,
  input  wire logic [ChW-1:0]   color_ch1_i,
  input  wire logic [ChW-1:0]   color_ch2_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NumCh-1:0][ChW-1:0] pixel_t;
  typedef logic [NumVtx-1:0][WgtW-1:0] weight_vec_t;

  // shadow copies of the two tables
  vtx_vec_t tri_corners [TriDepth];
  off_vec_t vtx_offsets [VtxDepth];

  pixel_t expected_pixels [$];
  int     mismatches    = 0;
  int     pending_count = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending_count;

  task automatic report(input string what);
    if (mismatches < 50) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  // weighted membrane offset added to the source, exact, clamped then floored
  function automatic pixel_t blend_pixel(input logic [IdxW-1:0] tri_idx,
                                         input weight_vec_t wgt,
                                         input logic [ColW-1:0] src);
    pixel_t   px;
    vtx_vec_t corners;
    off_vec_t offs;
    longint   acc [NumCh];
    longint   total;
    corners = '0;
    if (tri_idx < TriDepth) begin
      corners = tri_corners[tri_idx];
    end
    for (int c = 0; c < NumCh; c++) begin
      acc[c] = 0;
    end
    for (int k = 0; k < NumVtx; k++) begin
      offs = '0;
      if (corners[k] < VtxDepth) begin
        offs = vtx_offsets[corners[k]];
      end
      for (int c = 0; c < NumCh; c++) begin
        acc[c] += longint'($signed(wgt[k])) * longint'($signed(offs[c]));
      end
    end
    for (int c = 0; c < NumCh; c++) begin
      total = (longint'(src[ChW*c +: ChW]) <<< FracBits) + acc[c];
      if (total < 0) begin
        px[c] = '0;
      end else if ((total >>> FracBits) > ((1 << ChW) - 1)) begin
        px[c] = '1;
      end else begin
        px[c] = total[FracBits +: ChW];
      end
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      expected_pixels.delete();
      pending_count = 0;
    end else begin
      if (start_i && !busy_i) begin
        case (operation_i)
          OpWriteTri: begin
            if (entry_index_i < TriDepth) begin
              tri_corners[entry_index_i] = {vertex_c_i, vertex_b_i, vertex_a_i};
            end
          end
          OpWriteMem: begin
            if (entry_index_i < VtxDepth) begin
              vtx_offsets[entry_index_i] = {offset_ch2_i, offset_ch1_i, offset_ch0_i};
            end
          end
          OpBlend: begin
            expected_pixels.insert(expected_pixels.size(), blend_pixel(entry_index_i,
                {weight_three_i, weight_two_i, weight_one_i}, source_color_i));
          end
          default: begin
            expected_pixels.insert(expected_pixels.size(), source_color_i);
          end
        endcase
      end
      if (result_valid_i) begin
        if (expected_pixels.size() == 0) begin
          report("result with no transaction outstanding");
        end else begin
          want = expected_pixels.pop_front();
          if (color_ch0_i !== want[0]) begin
            report($sformatf("color_ch0 got %0d expected %0d", color_ch0_i, want[0]));
          end
          if (color_ch1_i !== want[1]) begin
            report($sformatf("color_ch1 got %0d expected %0d", color_ch1_i, want[1]));
          end
          if (color_ch2_i !== want[2]) begin
            report($sformatf("color_ch2 got %0d expected %0d", color_ch2_i, want[2]));
          end
        end
      end
      pending_count = expected_pixels.size();
    end
  end

endmodule

// File: bench/membrane_interpolate_blend_unit_tb.sv
module membrane_interpolate_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mib_pkg::*;

  // number of transactions issued before the drain
  localparam int ItemTarget = 1200;
  // Q2.14 value of one
  localparam int WeightOne  = 1 << 14;
  // largest offset magnitude that software loads
  localparam int OffsetMax  = 4080;

  typedef logic [NumVtx-1:0][WgtW-1:0] weight_vec_t;

  // one command transaction, every field carried even when the op ignores it
  typedef struct {
    op_e             op;
    logic [IdxW-1:0] idx;
    vtx_vec_t        vtx;
    off_vec_t        off;
    weight_vec_t     wgt;
    logic [ColW-1:0] src;
  } cmd_t;

  logic            clk            = 1'b0;
  logic            rst_n          = 1'b0;
  logic            start          = 1'b0;
  logic            busy;
  logic [1:0]      operation      = '0;
  logic [IdxW-1:0] entry_index    = '0;
  logic [IdxW-1:0] vertex_a       = '0;
  logic [IdxW-1:0] vertex_b       = '0;
  logic [IdxW-1:0] vertex_c       = '0;
  logic [OffW-1:0] offset_ch0     = '0;
  logic [OffW-1:0] offset_ch1     = '0;
  logic [OffW-1:0] offset_ch2     = '0;
  logic [WgtW-1:0] weight_one     = '0;
  logic [WgtW-1:0] weight_two     = '0;
  logic [WgtW-1:0] weight_three   = '0;
  logic [ColW-1:0] source_color   = '0;
  logic            result_valid;
  logic [ChW-1:0]  color_ch0;
  logic [ChW-1:0]  color_ch1;
  logic [ChW-1:0]  color_ch2;
  int              mismatches;
  int              pending;

  // what software has loaded so far: blends only name triangles whose
  // entry and all three corner vertices were written before
  bit       vtx_ok  [VtxDepth];
  bit       tri_ok  [TriDepth];
  vtx_vec_t tri_vtx [TriDepth];
  int       vtx_list [$];
  int       tri_list [$];

  // sender burst state
  int  sent       = 0;
  int  burst_left = 0;
  bit  start_held = 1'b0;

  always #5 clk = ~clk;

  membrane_interpolate_blend_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .operation_i    (operation),
    .entry_index_i  (entry_index),
    .vertex_a_i     (vertex_a),
    .vertex_b_i     (vertex_b),
    .vertex_c_i     (vertex_c),
    .offset_ch0_i   (offset_ch0),
    .offset_ch1_i   (offset_ch1),
    .offset_ch2_i   (offset_ch2),
    .weight_one_i   (weight_one),
    .weight_two_i   (weight_two),
    .weight_three_i (weight_three),
    .source_color_i (source_color),
    .result_valid_o (result_valid),
    .color_ch0_o    (color_ch0),
    .color_ch1_o    (color_ch1),
    .color_ch2_o    (color_ch2)
  );

  // watches both channels, predicts every result and compares
  membrane_blend_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .operation_i    (operation),
    .entry_index_i  (entry_index),
    .vertex_a_i     (vertex_a),
    .vertex_b_i     (vertex_b),
    .vertex_c_i     (vertex_c),
    .offset_ch0_i   (offset_ch0),
    .offset_ch1_i   (offset_ch1),
    .offset_ch2_i   (offset_ch2),
    .weight_one_i   (weight_one),
    .weight_two_i   (weight_two),
    .weight_three_i (weight_three),
    .source_color_i (source_color),
    .result_valid_i (result_valid),
    .color_ch0_i    (color_ch0),
    .color_ch1_i    (color_ch1),
    .color_ch2_i    (color_ch2),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // random content for every field, later overwritten where the op uses it
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.op  = op_e'($urandom_range(0, 3));
    c.idx = IdxW'($urandom());
    for (int k = 0; k < NumVtx; k++) begin
      c.vtx[k] = IdxW'($urandom());
      c.wgt[k] = WgtW'($urandom());
    end
    for (int k = 0; k < NumCh; k++) begin
      c.off[k] = OffW'($urandom());
    end
    c.src = ColW'($urandom());
    return c;
  endfunction

  function automatic cmd_t vtx_cmd(input int idx, input int o0, input int o1, input int o2);
    cmd_t c;
    c = noise_cmd();
    c.op  = OpWriteMem;
    c.idx = IdxW'(idx);
    c.off = {OffW'(o2), OffW'(o1), OffW'(o0)};
    return c;
  endfunction

  function automatic cmd_t tri_cmd(input int idx, input int a, input int b, input int v3);
    cmd_t c;
    c = noise_cmd();
    c.op  = OpWriteTri;
    c.idx = IdxW'(idx);
    c.vtx = {IdxW'(v3), IdxW'(b), IdxW'(a)};
    return c;
  endfunction

  function automatic cmd_t blend_cmd(input int idx, input weight_vec_t wgt,
                                     input logic [ColW-1:0] src);
    cmd_t c;
    c = noise_cmd();
    c.op  = OpBlend;
    c.idx = IdxW'(idx);
    c.wgt = wgt;
    c.src = src;
    return c;
  endfunction

  function automatic cmd_t pass_cmd(input logic [ColW-1:0] src);
    cmd_t c;
    c = noise_cmd();
    c.op  = OpPass;
    c.src = src;
    return c;
  endfunction

  function automatic weight_vec_t weights(input int w0, input int w1, input int w2);
    return {WgtW'(w2), WgtW'(w1), WgtW'(w0)};
  endfunction

  // offsets stay inside the loaded range, with the extremes now and then
  function automatic int rand_offset();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return OffsetMax;
    if (pick == 1) return -OffsetMax;
    return int'($urandom_range(0, 2 * OffsetMax)) - OffsetMax;
  endfunction

  // half the time true barycentric weights summing to one, else extremes or noise
  function automatic weight_vec_t rand_weights();
    int pick;
    int a;
    int b;
    weight_vec_t w;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      a = $urandom_range(0, WeightOne);
      b = $urandom_range(0, WeightOne - a);
      return weights(a, b, WeightOne - a - b);
    end
    for (int k = 0; k < NumVtx; k++) begin
      if (pick == 5) begin
        w[k] = $urandom_range(0, 1) ? {1'b1, {(WgtW-1){1'b0}}} : {1'b0, {(WgtW-1){1'b1}}};
      end else begin
        w[k] = WgtW'($urandom());
      end
    end
    return w;
  endfunction

  function automatic logic [ColW-1:0] rand_color();
    return ColW'($urandom());
  endfunction

  // corner vertices mostly come from loaded entries, a few point anywhere
  function automatic int pick_vertex();
    if ($urandom_range(0, 99) < 85) begin
      return vtx_list[$urandom_range(0, vtx_list.size() - 1)];
    end
    return $urandom_range(0, VtxDepth - 1);
  endfunction

  function automatic bit tri_usable(input int t);
    return tri_ok[t] && vtx_ok[tri_vtx[t][0]] && vtx_ok[tri_vtx[t][1]]
        && vtx_ok[tri_vtx[t][2]];
  endfunction

  // a blend on a fully loaded triangle, or a pass pixel if none turns up
  function automatic cmd_t random_blend();
    int t;
    for (int tries = 0; tries < 4; tries++) begin
      t = tri_list[$urandom_range(0, tri_list.size() - 1)];
      if (tri_usable(t)) return blend_cmd(t, rand_weights(), rand_color());
    end
    return pass_cmd(rand_color());
  endfunction

  // put a command on the field ports
  task automatic put(input cmd_t c);
    operation    <= c.op;
    entry_index  <= c.idx;
    vertex_a     <= c.vtx[0];
    vertex_b     <= c.vtx[1];
    vertex_c     <= c.vtx[2];
    offset_ch0   <= c.off[0];
    offset_ch1   <= c.off[1];
    offset_ch2   <= c.off[2];
    weight_one   <= c.wgt[0];
    weight_two   <= c.wgt[1];
    weight_three <= c.wgt[2];
    source_color <= c.src;
  endtask

  // issue one transaction, wait for the accepting edge, then maybe pause
  task automatic send(input cmd_t c);
    int gap;
    case (c.op)
      OpWriteMem: begin
        if (!vtx_ok[c.idx]) begin
          vtx_ok[c.idx] = 1'b1;
          vtx_list.insert(vtx_list.size(), int'(c.idx));
        end
      end
      OpWriteTri: begin
        tri_vtx[c.idx] = c.vtx;
        if (!tri_ok[c.idx]) begin
          tri_ok[c.idx] = 1'b1;
          tri_list.insert(tri_list.size(), int'(c.idx));
        end
      end
      default: ;
    endcase
    put(c);
    start      <= 1'b1;
    start_held  = 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap between bursts, with junk on the fields while start is low
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      start      <= 1'b0;
      start_held  = 1'b0;
      put(noise_cmd());
      repeat (gap) @(posedge clk);
      // long bursts leave stretches with no idle cycle at all
      burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60) : $urandom_range(0, 7);
    end
  endtask

  initial begin : stimulus
    int pick;
    int idx;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the extremes: full positive and negative offsets, both ends of
    // both tables, a unit offset and a mixed one
    send(vtx_cmd(0, OffsetMax, OffsetMax, OffsetMax));
    send(vtx_cmd(VtxDepth - 1, -OffsetMax, -OffsetMax, -OffsetMax));
    send(vtx_cmd(1, 16, -16, 0));
    send(vtx_cmd(2, OffsetMax, -OffsetMax, 0));
    send(tri_cmd(0, 0, 0, 0));
    send(tri_cmd(TriDepth - 1, VtxDepth - 1, VtxDepth - 1, VtxDepth - 1));
    send(tri_cmd(1, 0, VtxDepth - 1, 1));
    send(tri_cmd(2, 1, 2, VtxDepth - 1));

    // clamp at the top and at the bottom from every corner of the weight range
    send(blend_cmd(0, weights(32767, 32767, 32767), 24'h000000));
    send(blend_cmd(0, weights(-32768, -32768, -32768), 24'hffffff));
    send(blend_cmd(TriDepth - 1, weights(-32768, -32768, -32768), 24'h000000));
    send(blend_cmd(TriDepth - 1, weights(32767, 32767, 32767), 24'hffffff));
    // zero weights and cancelling weights leave the source untouched
    send(blend_cmd(1, weights(0, 0, 0), 24'h123456));
    send(blend_cmd(1, weights(WeightOne, WeightOne, 0), 24'h654321));
    // unit offset, plus one on channel 0 and minus one on channel 1
    send(blend_cmd(2, weights(WeightOne, 0, 0), 24'h807f00));
    // a tiny negative fraction floors down, a tiny positive one does not
    send(blend_cmd(2, weights(-1, 0, 0), 24'h010101));
    send(blend_cmd(2, weights(1, 0, 0), 24'h010101));

    // pass pixels at both ends and one in between
    send(pass_cmd(24'h000000));
    send(pass_cmd(24'hffffff));
    send(pass_cmd(24'ha55a3c));

    // rewrites seen by the very next blend
    send(vtx_cmd(0, -16, 32, 0));
    send(blend_cmd(0, weights(WeightOne, 0, 0), 24'h808080));
    send(tri_cmd(0, 1, 1, 1));
    send(blend_cmd(0, weights(0, WeightOne, 0), 24'h808080));

    // random traffic: loads keep coming while pixels stream through
    while (sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        idx = ($urandom_range(0, 2) == 0) ? vtx_list[$urandom_range(0, vtx_list.size() - 1)]
                                          : $urandom_range(0, VtxDepth - 1);
        send(vtx_cmd(idx, rand_offset(), rand_offset(), rand_offset()));
      end else if (pick < 22) begin
        idx = ($urandom_range(0, 3) == 0) ? tri_list[$urandom_range(0, tri_list.size() - 1)]
                                          : $urandom_range(0, TriDepth - 1);
        send(tri_cmd(idx, pick_vertex(), pick_vertex(), pick_vertex()));
      end else if (pick < 80) begin
        send(random_blend());
      end else begin
        send(pass_cmd(rand_color()));
      end
    end
    if (start_held) begin
      start <= 1'b0;
    end

    // drain: every expected pixel back, then a wait to catch extras
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("membrane_interpolate_blend_unit_tb passed");
    end else begin
      $display("membrane_interpolate_blend_unit_tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("membrane_interpolate_blend_unit_tb failed");
    $finish;
  end

endmodule

// File: membrane_interpolate_blend_unit.f
rtl/mib_pkg.sv
rtl/mib_tri_store.sv
rtl/mib_mem_store.sv
rtl/mib_datapath.sv
rtl/membrane_interpolate_blend_unit.sv
bench/membrane_blend_checker.sv
bench/membrane_interpolate_blend_unit_tb.sv
